// File: src/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Constants, micro-op codes, microprogram and CORDIC arctangent table
// for the moon phase sequencer.
// ----------------------------------------------------------------------------
package mpd_pkg;

	localparam int KEPLER_STEPS = 6;
	localparam int CORDIC_STEPS = 24;
	localparam int MUL_DIGITS   = 3;
	localparam int DIV_BITS     = 34;
	localparam int KCNT_W       = (KEPLER_STEPS > 1) ? $clog2(KEPLER_STEPS) : 1;

	localparam logic [63:0] UDEG = 64'd360000000;

	localparam logic [63:0] SUN_RATE =
		((64'd1 << 40) * 64'd10000 + 64'd1826211) / 64'd3652422;
	localparam logic [63:0] MOON_RATE =
		((64'd13 << 40) + ((64'd1763966 << 40) + 64'd5000000) / 64'd10000000
		+ 64'd180) / 64'd360;
	localparam logic [63:0] ANOM_RATE =
		((64'd1114041 << 40) + 64'd5000000) / 64'd10000000 / 64'd360;

	localparam logic [31:0] SUN_EPOCH_LON    = 32'((64'd278833540 << 32) / UDEG);
	localparam logic [31:0] SUN_PERIGEE_LON  = 32'((64'd282596403 << 32) / UDEG);
	localparam logic [31:0] MOON_MEAN_LON    = 32'((64'd64975464 << 32) / UDEG);
	localparam logic [31:0] MOON_PERIGEE_LON = 32'((64'd349383063 << 32) / UDEG);

	localparam logic [63:0] AMP_EV  = (64'd1273900 << 32) / UDEG;
	localparam logic [63:0] AMP_AE  = (64'd185800 << 32) / UDEG;
	localparam logic [63:0] AMP_A3  = (64'd370000 << 32) / UDEG;
	localparam logic [63:0] AMP_EC  = (64'd6288600 << 32) / UDEG;
	localparam logic [63:0] AMP_A4  = (64'd214000 << 32) / UDEG;
	localparam logic [63:0] AMP_VAR = (64'd658300 << 32) / UDEG;

	localparam logic [63:0] ECC_Q30     = ((64'd16718 << 30) + 64'd500000) / 64'd1000000;
	localparam logic [63:0] ECC_TURN    = ((64'd16718 << 32) * 64'd1000) / 64'd6283185307;
	localparam logic [63:0] ECC_SQ_COMP = 64'd1073591763;
	localparam logic [63:0] SYN_Q24     = (64'd2953058868 << 24) / 64'd100000000;

	localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

	typedef logic [4:0] pc_t;

	typedef enum logic [1:0] {
		UNIT_MUL,
		UNIT_ROT,
		UNIT_VEC,
		UNIT_DIV
	} unit_t;

	typedef enum logic [4:0] {
		OP_SUN, OP_KROT, OP_KSIN, OP_KCOS, OP_KDIV, OP_EROT, OP_TSIN, OP_TANG,
		OP_MOON, OP_ANOM, OP_EVROT, OP_EV, OP_MROT, OP_AE, OP_A3, OP_CROT,
		OP_EC, OP_2ROT, OP_A4, OP_VROT, OP_VAR, OP_AROT, OP_AGE
	} op_t;

	typedef struct packed {
		op_t   op;
		unit_t unit;
		logic  loop;
		logic  last;
		pc_t   target;
	} uword_t;

	localparam pc_t PC_KROT = 5'd1;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = '{OP_SUN,   UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd1:  w = '{OP_KROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd2:  w = '{OP_KSIN,  UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd3:  w = '{OP_KCOS,  UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd4:  w = '{OP_KDIV,  UNIT_DIV, 1'b1, 1'b0, PC_KROT};
			5'd5:  w = '{OP_EROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd6:  w = '{OP_TSIN,  UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd7:  w = '{OP_TANG,  UNIT_VEC, 1'b0, 1'b0, PC_KROT};
			5'd8:  w = '{OP_MOON,  UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd9:  w = '{OP_ANOM,  UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd10: w = '{OP_EVROT, UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd11: w = '{OP_EV,    UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd12: w = '{OP_MROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd13: w = '{OP_AE,    UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd14: w = '{OP_A3,    UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd15: w = '{OP_CROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd16: w = '{OP_EC,    UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd17: w = '{OP_2ROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd18: w = '{OP_A4,    UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd19: w = '{OP_VROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd20: w = '{OP_VAR,   UNIT_MUL, 1'b0, 1'b0, PC_KROT};
			5'd21: w = '{OP_AROT,  UNIT_ROT, 1'b0, 1'b0, PC_KROT};
			5'd22: w = '{OP_AGE,   UNIT_MUL, 1'b0, 1'b1, PC_KROT};
			default: w = '{OP_AGE, UNIT_MUL, 1'b0, 1'b1, PC_KROT};
		endcase
		return w;
	endfunction

	function automatic logic [29:0] atan_turn(input logic [5:0] i);
		logic [29:0] a;
		case (i)
			6'd0:  a = 30'h20000000;
			6'd1:  a = 30'h12E4051E;
			6'd2:  a = 30'h09FB385B;
			6'd3:  a = 30'h051111D4;
			6'd4:  a = 30'h028B0D43;
			6'd5:  a = 30'h0145D7E1;
			6'd6:  a = 30'h00A2F61E;
			6'd7:  a = 30'h00517C55;
			6'd8:  a = 30'h0028BE53;
			6'd9:  a = 30'h00145F2F;
			6'd10: a = 30'h000A2F98;
			6'd11: a = 30'h000517CC;
			6'd12: a = 30'h00028BE6;
			6'd13: a = 30'h000145F3;
			6'd14: a = 30'h0000A2FA;
			6'd15: a = 30'h0000517D;
			6'd16: a = 30'h000028BE;
			6'd17: a = 30'h0000145F;
			6'd18: a = 30'h00000A30;
			6'd19: a = 30'h00000518;
			6'd20: a = 30'h0000028C;
			6'd21: a = 30'h00000146;
			6'd22: a = 30'h000000A3;
			6'd23: a = 30'h00000051;
			6'd24: a = 30'h00000029;
			6'd25: a = 30'h00000014;
			6'd26: a = 30'h0000000A;
			6'd27: a = 30'h00000005;
			6'd28: a = 30'h00000003;
			6'd29: a = 30'h00000001;
			6'd30: a = 30'h00000001;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

endpackage

// File: src/moon_phase_from_date.sv
// ----------------------------------------------------------------------------
// moon_phase_from_date
// Runs its microprogram in order: the first multiply, 6 Kepler passes
// (a rotation, two multiplies and a divide each), then eight CORDIC runs
// and ten multiplies, and raises the done strobe when the last multiply
// completes.
// A new date is taken only when not busy; busy stays high while the program runs.
// Reset clears the sequencer; the receiver cannot stall the done strobe.
// ----------------------------------------------------------------------------
module moon_phase_from_date (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [44:0] day_offset,
	output logic               done,
	output logic [16:0]        illumination,
	output logic [15:0]        phase_fraction,
	output logic [20:0]        age_days
);
	import mpd_pkg::*;

	// sequencer
	logic               busy_q, launched_q, done_q;
	pc_t                pc_q;
	logic [KCNT_W-1:0]  kcnt_q;
	uword_t             uw;
	logic               ustart, udone;

	// datapath registers
	logic signed [44:0] day_q;
	logic [31:0]        m_sun_q, e_q, lam_q, ml_q, mm_q, mmp_q, lp_q, age_q;
	logic signed [35:0] s_q, c_q, ev_q, ae_q, sum_q;
	logic signed [33:0] delta_q;
	logic [31:0]        den_q;
	logic [16:0]        illum_q;
	logic [15:0]        phase_q;
	logic [20:0]        aged_q;

	// multiplier
	logic [63:0]        ma_q, macc_q;
	logic [47:0]        mb_q;
	logic [1:0]         mk_q;
	logic               mrun_q, mdone_q, mneg_q;
	logic [63:0]        mul_a_c;
	logic [47:0]        mul_b_c;
	logic               mul_neg_c;
	logic [15:0]        mdig;
	logic [63:0]        mpp, mrnd;
	logic signed [35:0] q30;

	// CORDIC
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic [5:0]         ccnt_q;
	logic               crun_q, cdone_q, cflip_q;
	logic [31:0]        cang_c;
	logic signed [35:0] cxs, cys, cvx, cvy, cor_s, cor_c;
	logic signed [33:0] cat, za;
	logic               cpos;

	// divider
	logic [63:0]        rem_q, dv_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [5:0]         dcnt_q;
	logic               drun_q, ddone_q;
	logic [33:0]        dabs;

	// misc
	logic [31:0]        d_ml_lam, d_lp_lam;
	logic [35:0]        sabs, cabs;
	logic signed [36:0] il37;
	logic [35:0]        ilc, ilr;
	logic [63:0]        aged_sum;

	assign uw     = ucode(pc_q);
	assign ustart = busy_q && !launched_q;
	assign udone  = mdone_q | cdone_q | ddone_q;

	assign busy           = busy_q;
	assign done           = done_q;
	assign illumination   = illum_q;
	assign phase_fraction = phase_q;
	assign age_days       = aged_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			launched_q <= 1'b0;
			done_q     <= 1'b0;
			pc_q       <= '0;
			kcnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q     <= 1'b1;
					launched_q <= 1'b0;
					pc_q       <= '0;
				end
			end else if (!launched_q) begin
				launched_q <= 1'b1;
			end else if (udone) begin
				launched_q <= 1'b0;
				if (uw.op == OP_SUN)
					kcnt_q <= '0;
				if (uw.last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (uw.loop && kcnt_q != KCNT_W'(KEPLER_STEPS - 1)) begin
					pc_q   <= uw.target;
					kcnt_q <= kcnt_q + 1'b1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// operand selection
	assign sabs     = s_q[35] ? 36'(-s_q) : 36'(s_q);
	assign cabs     = c_q[35] ? 36'(-c_q) : 36'(c_q);
	assign d_ml_lam = ml_q - lam_q;
	assign d_lp_lam = lp_q - lam_q;

	always_comb begin
		mul_a_c   = {{19{day_q[44]}}, day_q};
		mul_b_c   = 48'(SUN_RATE);
		mul_neg_c = s_q[35];
		cang_c    = e_q;
		case (uw.op)
			OP_KSIN: begin mul_a_c = ECC_TURN;    mul_b_c = 48'(sabs); end
			OP_KCOS: begin
				mul_a_c = ECC_Q30; mul_b_c = 48'(cabs); mul_neg_c = c_q[35];
			end
			OP_TSIN: begin mul_a_c = ECC_SQ_COMP; mul_b_c = 48'(sabs); end
			OP_MOON: mul_b_c = 48'(MOON_RATE);
			OP_ANOM: mul_b_c = 48'(ANOM_RATE);
			OP_EV:   begin mul_a_c = AMP_EV;  mul_b_c = 48'(sabs); end
			OP_AE:   begin mul_a_c = AMP_AE;  mul_b_c = 48'(sabs); end
			OP_A3:   begin mul_a_c = AMP_A3;  mul_b_c = 48'(sabs); end
			OP_EC:   begin mul_a_c = AMP_EC;  mul_b_c = 48'(sabs); end
			OP_A4:   begin mul_a_c = AMP_A4;  mul_b_c = 48'(sabs); end
			OP_VAR:  begin mul_a_c = AMP_VAR; mul_b_c = 48'(sabs); end
			OP_AGE:  begin mul_a_c = {32'b0, age_q}; mul_b_c = 48'(SYN_Q24); end
			default: ;
		endcase
		case (uw.op)
			OP_EVROT: cang_c = (d_ml_lam << 1) - mm_q;
			OP_MROT:  cang_c = m_sun_q;
			OP_CROT:  cang_c = mmp_q;
			OP_2ROT:  cang_c = mmp_q << 1;
			OP_VROT:  cang_c = d_lp_lam << 1;
			OP_AROT:  cang_c = age_q;
			default:  cang_c = e_q;
		endcase
	end

	// multiplier: 64 x 16 per cycle over three digits, sum mod 2^64
	assign mdig = 16'(mb_q >> {mk_q, 4'b0});
	assign mpp  = (ma_q * {48'b0, mdig}) << {mk_q, 4'b0};
	assign mrnd = (macc_q + (64'd1 << 29)) >> 30;
	assign q30  = mneg_q ? -$signed(mrnd[35:0]) : $signed(mrnd[35:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q  <= 1'b0;
			mdone_q <= 1'b0;
			mk_q    <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (ustart && uw.unit == UNIT_MUL) begin
				mrun_q <= 1'b1;
				mk_q   <= '0;
			end else if (mrun_q) begin
				mk_q <= mk_q + 1'b1;
				if (mk_q == 2'(MUL_DIGITS - 1)) begin
					mrun_q  <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ustart && uw.unit == UNIT_MUL) begin
			ma_q   <= mul_a_c;
			mb_q   <= mul_b_c;
			mneg_q <= mul_neg_c;
			macc_q <= '0;
		end else if (mrun_q) begin
			macc_q <= macc_q + mpp;
		end
	end

	// CORDIC, rotation and vectoring on one set of registers
	assign za   = $signed({{2{cang_c[31]}}, cang_c});
	assign cvx  = c_q - $signed(36'(ECC_Q30));
	assign cvy  = ev_q;
	assign cxs  = cx_q >>> ccnt_q;
	assign cys  = cy_q >>> ccnt_q;
	assign cat  = $signed({4'b0, atan_turn(ccnt_q)});
	assign cpos = (uw.unit == UNIT_VEC) ? !(cy_q > 0) : (cz_q >= 0);
	assign cor_s = cflip_q ? -cy_q : cy_q;
	assign cor_c = cflip_q ? -cx_q : cx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crun_q  <= 1'b0;
			cdone_q <= 1'b0;
			ccnt_q  <= '0;
		end else begin
			cdone_q <= 1'b0;
			if (ustart && (uw.unit == UNIT_ROT || uw.unit == UNIT_VEC)) begin
				crun_q <= 1'b1;
				ccnt_q <= '0;
			end else if (crun_q) begin
				ccnt_q <= ccnt_q + 1'b1;
				if (ccnt_q == 6'(CORDIC_STEPS - 1)) begin
					crun_q  <= 1'b0;
					cdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ustart && uw.unit == UNIT_ROT) begin
			cx_q <= CORDIC_GAIN;
			cy_q <= '0;
			if (za > 34'sd1073741824) begin
				cz_q    <= za - 34'sd2147483648;
				cflip_q <= 1'b1;
			end else if (za < -34'sd1073741824) begin
				cz_q    <= za + 34'sd2147483648;
				cflip_q <= 1'b1;
			end else begin
				cz_q    <= za;
				cflip_q <= 1'b0;
			end
		end else if (ustart && uw.unit == UNIT_VEC) begin
			cx_q    <= cvx[35] ? -cvx : cvx;
			cy_q    <= cvx[35] ? -cvy : cvy;
			cz_q    <= '0;
			cflip_q <= cvx[35];
		end else if (crun_q) begin
			if (cpos) begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				cz_q <= cz_q - cat;
			end else begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				cz_q <= cz_q + cat;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign dabs = delta_q[33] ? 34'(-delta_q) : 34'(delta_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drun_q  <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (ustart && uw.unit == UNIT_DIV) begin
				drun_q <= 1'b1;
				dcnt_q <= '0;
			end else if (drun_q) begin
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 6'(DIV_BITS - 1)) begin
					drun_q  <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ustart && uw.unit == UNIT_DIV) begin
			rem_q <= {dabs, 30'b0};
			dv_q  <= {32'b0, den_q} << (DIV_BITS - 1);
			quo_q <= '0;
		end else if (drun_q) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
	end

	// illumination and age in days
	assign il37     = 37'sd1073741824 - 37'(cor_c);
	assign ilc      = il37[36] ? 36'd0 : il37[35:0];
	assign ilr      = (ilc + 36'd16384) >> 15;
	assign aged_sum = macc_q + (64'd1 << 39);

	// date capture at start; write-back at unit completion
	always_ff @(posedge clk) begin
		if (!busy_q && start)
			day_q <= day_offset;
		if (busy_q && launched_q && cdone_q && uw.unit == UNIT_ROT) begin
			s_q <= cor_s;
			c_q <= cor_c;
		end
		if (busy_q && launched_q && udone) begin
			case (uw.op)
				OP_SUN: begin
					m_sun_q <= macc_q[63:32] + SUN_EPOCH_LON - SUN_PERIGEE_LON;
					e_q     <= macc_q[63:32] + SUN_EPOCH_LON - SUN_PERIGEE_LON;
				end
				OP_KSIN: delta_q <= 34'($signed({{4{e_q[31] ^ m_sun_q[31] ^
					(e_q[30:0] < m_sun_q[30:0])}}, 32'(e_q - m_sun_q)}) - q30);
				OP_KCOS: den_q <= 32'(36'sd1073741824 - q30);
				OP_KDIV: e_q <= delta_q[33] ? e_q + quo_q[31:0] : e_q - quo_q[31:0];
				OP_TSIN: ev_q <= q30;
				OP_TANG: lam_q <= (cflip_q ? 32'h80000000 : 32'h0) + cz_q[31:0]
					+ SUN_PERIGEE_LON;
				OP_MOON: ml_q <= macc_q[63:32] + MOON_MEAN_LON;
				OP_ANOM: mm_q <= ml_q - macc_q[63:32] - MOON_PERIGEE_LON;
				OP_EV:   ev_q <= q30;
				OP_AE:   ae_q <= q30;
				OP_A3:   mmp_q <= mm_q + 32'(ev_q - ae_q - q30);
				OP_EC:   sum_q <= ev_q - ae_q + q30;
				OP_A4:   lp_q <= ml_q + 32'(sum_q + q30);
				OP_VAR:  age_q <= lp_q + 32'(q30) - lam_q;
				OP_AROT: illum_q <= (ilr > 36'd65536) ? 17'd65536 : ilr[16:0];
				OP_AGE: begin
					aged_q  <= aged_sum[60:40];
					phase_q <= age_q[31:16];
				end
				default: ;
			endcase
		end
	end

endmodule

// File: bench/tb_moon_phase_from_date.sv
// ----------------------------------------------------------------------------
// tb_moon_phase_from_date
// Drives dates into the moon phase sequencer and checks every done strobe
// against a bit-exact predictor of the fixed-point lunar phase computation.
// ----------------------------------------------------------------------------
module tb_moon_phase_from_date;
	import mpd_pkg::*;

	localparam int LATENCY = 696;
	localparam logic [63:0] DAY_MASK = (64'd1 << 45) - 64'd1;
	localparam longint Q30_ONE = 64'sd1073741824;

	typedef struct packed {
		logic [16:0] illum;
		logic [15:0] phase;
		logic [20:0] age;
	} phase_t;

	typedef struct {
		logic signed [44:0] day;
		logic               fixed;
		phase_t             res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [44:0] day_offset = '0;
	logic               busy, done;
	logic [16:0]        illumination;
	logic [15:0]        phase_fraction;
	logic [20:0]        age_days;

	phase_t pending_phase[$];
	int     n_mismatch = 0;
	int     n_checked = 0;
	int     n_sent = 0;
	int     idle_pct = 0;

	moon_phase_from_date u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.day_offset(day_offset), .done(done), .illumination(illumination),
		.phase_fraction(phase_fraction), .age_days(age_days)
	);

	always #6 clk = ~clk;

	function automatic longint turn_s(logic [31:0] u);
		return longint'(signed'(u));
	endfunction

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint mulq30(longint a, longint s);
		logic       neg;
		logic [63:0] ma, ms, r;
		neg = (a < 0) != (s < 0);
		ma = (a < 0) ? -a : a;
		ms = (s < 0) ? -s : s;
		r = (ma * ms + (64'd1 << 29)) >> 30;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic void rotate(input logic [31:0] ang, output longint s,
		output longint c);
		longint z, x, y, nx;
		logic   flip;
		z = turn_s(ang);
		x = longint'(CORDIC_GAIN);
		y = 0;
		flip = 1'b0;
		if (z > Q30_ONE) begin
			z -= 2 * Q30_ONE;
			flip = 1'b1;
		end else if (z < -Q30_ONE) begin
			z += 2 * Q30_ONE;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 40; i++) begin
			if (z >= 0) begin
				nx = x - fshift(y, i);
				y = y + fshift(x, i);
				z -= longint'(atan_turn(6'(i)));
			end else begin
				nx = x + fshift(y, i);
				y = y - fshift(x, i);
				z += longint'(atan_turn(6'(i)));
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic logic [31:0] vector_angle(longint y, longint x);
		logic [31:0] base;
		longint      z, nx;
		base = 0;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = 32'h80000000;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 40; i++) begin
			if (y > 0) begin
				nx = x + fshift(y, i);
				y = y - fshift(x, i);
				z += longint'(atan_turn(6'(i)));
			end else begin
				nx = x - fshift(y, i);
				y = y + fshift(x, i);
				z -= longint'(atan_turn(6'(i)));
			end
			x = nx;
		end
		return base + 32'(z);
	endfunction

	function automatic longint amp_sine(logic [63:0] amp, logic [31:0] ang);
		longint s, c;
		rotate(ang, s, c);
		return mulq30(longint'(amp), s);
	endfunction

	function automatic phase_t predict_phase(logic signed [44:0] d);
		logic [63:0] day, t64;
		logic [31:0] m_sun, e, lam, ml, mm, mmp, lp, lpp, age;
		longint      s, c, delta, den, ev, ae, a3, illum;
		phase_t      r;
		day = 64'(d);
		t64 = day * SUN_RATE;
		m_sun = t64[63:32] + SUN_EPOCH_LON - SUN_PERIGEE_LON;
		e = m_sun;
		for (int i = 0; i < KEPLER_STEPS; i++) begin
			rotate(e, s, c);
			delta = turn_s(e - m_sun) - mulq30(longint'(ECC_TURN), s);
			den = Q30_ONE - mulq30(longint'(ECC_Q30), c);
			e = e + 32'(-((delta * Q30_ONE) / den));
		end
		rotate(e, s, c);
		lam = vector_angle(mulq30(longint'(ECC_SQ_COMP), s), c - longint'(ECC_Q30))
			+ SUN_PERIGEE_LON;
		t64 = day * MOON_RATE;
		ml = t64[63:32] + MOON_MEAN_LON;
		t64 = day * ANOM_RATE;
		mm = ml - t64[63:32] - MOON_PERIGEE_LON;
		ev = amp_sine(AMP_EV, 32'd2 * (ml - lam) - mm);
		ae = amp_sine(AMP_AE, m_sun);
		a3 = amp_sine(AMP_A3, m_sun);
		mmp = mm + 32'(ev - ae - a3);
		lp = ml + 32'(ev + amp_sine(AMP_EC, mmp) - ae + amp_sine(AMP_A4, 32'd2 * mmp));
		lpp = lp + 32'(amp_sine(AMP_VAR, 32'd2 * (lp - lam)));
		age = lpp - lam;
		rotate(age, s, c);
		illum = Q30_ONE - c;
		if (illum < 0)
			illum = 0;
		illum = (illum + 16384) >>> 15;
		if (illum > 65536)
			illum = 65536;
		r.illum = 17'(illum);
		r.phase = age[31:16];
		t64 = (64'(age) * SYN_Q24 + (64'd1 << 39)) >> 40;
		r.age = t64[20:0];
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		n_mismatch++;
		$display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		phase_t w;
		if (done) begin
			if (pending_phase.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				w = pending_phase.pop_front();
				n_checked++;
				if (illumination !== w.illum)
					report("illumination", illumination, w.illum);
				if (phase_fraction !== w.phase)
					report("phase_fraction", phase_fraction, w.phase);
				if (age_days !== w.age)
					report("age_days", age_days, w.age);
			end
		end
	end

	task automatic send_date(input logic signed [44:0] d, input logic fixed, input phase_t res);
		phase_t p;
		while ($urandom_range(99) < idle_pct)
			@(posedge clk);
		p = predict_phase(d);
		if (fixed && p != res)
			report("predictor vs table", p.phase, res.phase);
		start <= 1'b1;
		day_offset <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_phase.push_back(p);
		n_sent++;
		start <= 1'b0;
		day_offset <= 45'(signed'({$urandom, $urandom}));
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic signed [44:0] rand_date();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return 45'(r);
			1: return 45'(signed'(r[38:0]) - (longint'(1) << 37));
			2: return 45'(signed'(r[33:0]));
			default: return 45'($urandom_range(20000) - 10000) <<< 24;
		endcase
	endfunction

	// date 0 gives age 0 only if the model says so; typed rows hold no result
	row_t directed[] = '{
		'{45'sd0, 1'b0, '{0, 0, 0}},
		'{-45'sd1, 1'b0, '{0, 0, 0}},
		'{45'sd1, 1'b0, '{0, 0, 0}},
		'{45'h0FFFFFFFFFFF, 1'b0, '{0, 0, 0}},
		'{45'h100000000000, 1'b0, '{0, 0, 0}},
		'{45'h1FFFFFFFFFFF, 1'b0, '{0, 0, 0}},
		'{45'h155555555555, 1'b0, '{0, 0, 0}},
		'{45'h0AAAAAAAAAAA, 1'b0, '{0, 0, 0}},
		'{45'sd1 <<< 24, 1'b0, '{0, 0, 0}},
		'{-(45'sd1 <<< 24), 1'b0, '{0, 0, 0}},
		'{45'sd15 <<< 24, 1'b0, '{0, 0, 0}},
		'{45'sd29 <<< 24, 1'b0, '{0, 0, 0}},
		'{45'sd365 <<< 24, 1'b0, '{0, 0, 0}},
		'{45'sd16000 <<< 24, 1'b0, '{0, 0, 0}},
		'{-(45'sd16000 <<< 24), 1'b0, '{0, 0, 0}},
		'{45'sd524287 <<< 24, 1'b0, '{0, 0, 0}}
	};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_date(directed[i].day, directed[i].fixed, directed[i].res);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 69 : (ph == 2) ? 21 : 0;
			for (int k = 0; k < 320; k++)
				send_date(rand_date(), 1'b0, '{0, 0, 0});
		end
		while (pending_phase.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d dates, checked %0d results across full 45-bit range",
			n_sent, n_checked);
		if (n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(12 * 1400 * 4000);
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
